// ----- sv/fts_pkg.sv -----
`timescale 1ns / 1ps
package fts_pkg;
  localparam int unsigned VAL_W = 24;
  localparam int unsigned CNT_W = 32;
  localparam int unsigned CCNT_W = 16;
  localparam int unsigned RANK_W = 6;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;
  localparam logic FUNC_ADD = 1'b0;
  localparam logic FUNC_CLEAR = 1'b1;

  // Request handed to the mean-step divider
  typedef struct packed {
    logic               start;
    logic [VAL_W-1:0]   old;
    logic [VAL_W-1:0]   x;
    logic [CNT_W-1:0]   n;
  } div_req_t;
endpackage

// ----- sv/frame_time_statistics.sv -----
`timescale 1ns / 1ps
// Channel | Dir | Handshake            | Content
// in_     | in  | in_valid/in_ready    | func, sample, critical flag, critical count
// out_    | out | out_valid/out_ready  | statistics plus one top-list rank per beat
// cfg_    | in  | cfg_we               | budget_ms
// An add runs the serial divider for the mean and for the deviation, and a third time
// only for a critical over-budget sample; the walk then reads and writes back each
// visited top-list entry. The first add after reset or a clear only sets the mean
// and count. A clear skips the divider and walks all TOP_COUNT entries. Output
// streams TOP_COUNT beats, stalling on out_ready; in_ready stays low until the last
// beat is taken. Reset clears the top-list memory before in_ready rises.
module frame_time_statistics #(
  parameter int TOP_COUNT = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_func,
  input  logic [23:0] in_sample_ms,
  input  logic        in_in_critical_frame,
  input  logic [15:0] in_critical_frame_count,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_count,
  output logic [23:0] out_mean_ms,
  output logic [23:0] out_mean_abs_dev_ms,
  output logic [23:0] out_max_ms,
  output logic [31:0] out_over_budget,
  output logic [31:0] out_critical_over_budget,
  output logic [23:0] out_critical_mean_ms,
  output logic [5:0]  out_rank,
  output logic [23:0] out_top_value_ms,
  output logic        out_last,
  input  logic        cfg_we,
  input  logic [23:0] cfg_budget_ms
);
  import fts_pkg::*;

  localparam int AW = (TOP_COUNT > 1) ? $clog2(TOP_COUNT) : 1;
  localparam logic [AW:0] TOPN = (AW+1)'(TOP_COUNT);

  typedef enum logic [8:0] {
    S_INIT  = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_MEAN  = 9'b000000100,
    S_DEV   = 9'b000001000,
    S_CRIT  = 9'b000010000,
    S_WRD   = 9'b000100000,
    S_WWR   = 9'b001000000,
    S_ORD   = 9'b010000000,
    S_OUT   = 9'b100000000
  } state_t;

  state_t            st_r, st_nxt;
  logic [VAL_W-1:0]  top_mem [TOP_COUNT];
  logic [VAL_W-1:0]  rd_q;
  logic              we;
  logic [AW-1:0]     waddr, raddr;
  logic [VAL_W-1:0]  wdata;

  logic [VAL_W-1:0]  budget_r;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt, ovr_r, ovr_nxt, covr_r, covr_nxt;
  logic [VAL_W-1:0]  mean_r, mean_nxt, dev_r, dev_nxt, max_r, max_nxt;
  logic [VAL_W-1:0]  cmean_r, cmean_nxt;
  logic [VAL_W-1:0]  x_r, x_nxt;
  logic              func_r, func_nxt, crit_r, crit_nxt;
  logic [CCNT_W-1:0] cc_r, cc_nxt;
  logic [AW:0]       idx_r, idx_nxt, lim_r, lim_nxt;
  logic              ovalid_r, ovalid_nxt;
  logic [VAL_W-1:0]  otop_r, otop_nxt;
  logic [AW:0]       orank_r, orank_nxt;

  div_req_t          dreq;
  logic              ddone;
  logic [VAL_W-1:0]  dres;
  logic [VAL_W-1:0]  absd;

  fts_mean_step u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .done(ddone), .res(dres));

  // Top-list memory, one write and one registered read
  always_ff @(posedge clk) begin
    if (we) top_mem[waddr] <= wdata;
    rd_q <= top_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) budget_r <= '0;
    else if (cfg_we) budget_r <= cfg_budget_ms;
  end

  assign absd = (x_r >= dres) ? x_r - dres : dres - x_r;
  // Hold off new beats until the last result beat has left
  assign in_ready = (st_r == S_IDLE) && !ovalid_r;

  always_comb begin
    st_nxt = st_r;
    cnt_nxt = cnt_r; ovr_nxt = ovr_r; covr_nxt = covr_r;
    mean_nxt = mean_r; dev_nxt = dev_r; max_nxt = max_r; cmean_nxt = cmean_r;
    x_nxt = x_r; func_nxt = func_r; crit_nxt = crit_r; cc_nxt = cc_r;
    idx_nxt = idx_r; lim_nxt = lim_r;
    ovalid_nxt = ovalid_r; otop_nxt = otop_r; orank_nxt = orank_r;
    dreq = '0;
    we = 1'b0; waddr = idx_r[AW-1:0]; wdata = '0;
    raddr = idx_r[AW-1:0];
    case (st_r)
      S_INIT: begin
        we = 1'b1;
        idx_nxt = idx_r + 1'b1;
        if (idx_r == TOPN - 1'b1) st_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid && in_ready) begin
          func_nxt = in_func;
          x_nxt = in_sample_ms;
          crit_nxt = in_in_critical_frame;
          cc_nxt = in_critical_frame_count;
          idx_nxt = '0;
          if (in_func == FUNC_CLEAR) begin
            cnt_nxt = '0; ovr_nxt = '0; covr_nxt = '0;
            mean_nxt = '0; dev_nxt = '0; max_nxt = '0; cmean_nxt = '0;
            lim_nxt = TOPN;
            st_nxt = S_WRD;
          end else if (cnt_r == '0) begin
            cnt_nxt = 32'd1;
            mean_nxt = in_sample_ms;
            dev_nxt = '0;
            max_nxt = '0;
            idx_nxt = '0;
            st_nxt = S_ORD;
          end else begin
            cnt_nxt = (cnt_r == CNT_MAX) ? cnt_r : cnt_r + 1'b1;
            dreq.start = 1'b1;
            dreq.old = mean_r;
            dreq.x = in_sample_ms;
            dreq.n = (cnt_r == CNT_MAX) ? cnt_r : cnt_r + 1'b1;
            st_nxt = S_MEAN;
          end
        end
      end
      S_MEAN: begin
        if (ddone) begin
          mean_nxt = dres;
          dreq.start = 1'b1;
          dreq.old = dev_r;
          dreq.x = absd;
          dreq.n = cnt_r;
          st_nxt = S_DEV;
        end
      end
      S_DEV: begin
        if (ddone) begin
          dev_nxt = dres;
          if (x_r > max_r) max_nxt = x_r;
          lim_nxt = (cnt_r < CNT_W'(TOP_COUNT)) ? cnt_r[AW:0] : TOPN;
          st_nxt = S_WRD;
          if (budget_r != '0 && x_r > budget_r) begin
            ovr_nxt = (ovr_r == CNT_MAX) ? ovr_r : ovr_r + 1'b1;
            if (crit_r) begin
              covr_nxt = (covr_r == CNT_MAX) ? covr_r : covr_r + 1'b1;
              dreq.start = 1'b1;
              dreq.old = cmean_r;
              dreq.x = x_r;
              dreq.n = (cc_r == '0) ? 32'd1 : {16'd0, cc_r};
              st_nxt = S_CRIT;
            end
          end
        end
      end
      S_CRIT: begin
        if (ddone) begin
          cmean_nxt = dres;
          st_nxt = S_WRD;
        end
      end
      // Read an entry for the insertion walk
      S_WRD: begin
        if (idx_r == lim_r) begin
          idx_nxt = '0;
          st_nxt = S_ORD;
        end else begin
          st_nxt = S_WWR;
        end
      end
      // Write back: zero on clear, swap where the carried sample wins
      S_WWR: begin
        if (func_r == FUNC_CLEAR) begin
          we = 1'b1;
        end else if (x_r > rd_q) begin
          we = 1'b1;
          wdata = x_r;
          x_nxt = rd_q;
        end
        idx_nxt = idx_r + 1'b1;
        st_nxt = S_WRD;
      end
      S_ORD: begin
        if (!ovalid_r || out_ready) begin
          ovalid_nxt = 1'b0;
          st_nxt = S_OUT;
        end
      end
      // Present the read entry, then fetch the next rank
      S_OUT: begin
        ovalid_nxt = 1'b1;
        otop_nxt = rd_q;
        orank_nxt = idx_r;
        idx_nxt = idx_r + 1'b1;
        if (idx_r == TOPN - 1'b1) st_nxt = S_IDLE;
        else st_nxt = S_ORD;
      end
      default: st_nxt = S_IDLE;
    endcase
    if (st_r != S_ORD && st_r != S_OUT && ovalid_r && out_ready) ovalid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_INIT;
      idx_r <= '0;
      ovalid_r <= 1'b0;
      cnt_r <= '0; ovr_r <= '0; covr_r <= '0;
      mean_r <= '0; dev_r <= '0; max_r <= '0; cmean_r <= '0;
    end else begin
      st_r <= st_nxt;
      idx_r <= idx_nxt;
      ovalid_r <= ovalid_nxt;
      cnt_r <= cnt_nxt; ovr_r <= ovr_nxt; covr_r <= covr_nxt;
      mean_r <= mean_nxt; dev_r <= dev_nxt; max_r <= max_nxt; cmean_r <= cmean_nxt;
    end
    x_r <= x_nxt; func_r <= func_nxt; crit_r <= crit_nxt; cc_r <= cc_nxt;
    lim_r <= lim_nxt; otop_r <= otop_nxt; orank_r <= orank_nxt;
  end

  assign out_valid = ovalid_r;
  assign out_count = cnt_r;
  assign out_mean_ms = mean_r;
  assign out_mean_abs_dev_ms = dev_r;
  assign out_max_ms = max_r;
  assign out_over_budget = ovr_r;
  assign out_critical_over_budget = covr_r;
  assign out_critical_mean_ms = cmean_r;
  assign out_rank = RANK_W'(orank_r);
  assign out_top_value_ms = otop_r;
  assign out_last = (orank_r == TOPN - 1'b1);
endmodule

// ----- sv/fts_mean_step.sv -----
`timescale 1ns / 1ps
// Computes old + (x - old) / n, quotient truncated toward zero, one bit a cycle.
module fts_mean_step (
  input  logic              clk,
  input  logic              rst_n,
  input  fts_pkg::div_req_t req,
  output logic              done,
  output logic [23:0]       res
);
  import fts_pkg::*;

  logic              busy_r, busy_nxt;
  logic [5:0]        cnt_r, cnt_nxt;
  logic [VAL_W-1:0]  old_r, old_nxt;
  logic              neg_r, neg_nxt;
  logic [VAL_W-1:0]  quo_r, quo_nxt;
  logic [VAL_W-1:0]  num_r, num_nxt;
  logic [CNT_W:0]    rem_r, rem_nxt;
  logic [CNT_W-1:0]  den_r, den_nxt;
  logic              done_r, done_nxt;
  logic [CNT_W:0]    trial;
  logic [VAL_W-1:0]  mag;

  assign mag = (req.x >= req.old) ? req.x - req.old : req.old - req.x;
  assign trial = {rem_r[CNT_W-1:0], num_r[VAL_W-1]};

  // Restoring division over the 24-bit difference magnitude
  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    old_nxt  = old_r;
    neg_nxt  = neg_r;
    quo_nxt  = quo_r;
    num_nxt  = num_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    done_nxt = 1'b0;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 6'(VAL_W);
      old_nxt  = req.old;
      neg_nxt  = req.x < req.old;
      num_nxt  = mag;
      rem_nxt  = '0;
      quo_nxt  = '0;
      den_nxt  = req.n;
    end else if (busy_r) begin
      num_nxt = {num_r[VAL_W-2:0], 1'b0};
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = trial - {1'b0, den_r};
        quo_nxt = {quo_r[VAL_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        quo_nxt = {quo_r[VAL_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    old_r <= old_nxt;
    neg_r <= neg_nxt;
    quo_r <= quo_nxt;
    num_r <= num_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign done = done_r;
  assign res  = neg_r ? old_r - quo_r : old_r + quo_r;
endmodule

// ----- tb/sv/tb_frame_time_statistics.sv -----
`timescale 1ns / 1ps
module tb_frame_time_statistics;
  import fts_pkg::*;

  localparam int TOPN = 16;
  localparam int CNT_LIMIT = 200000;

  typedef struct {
    logic [31:0] count;
    logic [23:0] mean;
    logic [23:0] mad;
    logic [23:0] maxv;
    logic [31:0] over;
    logic [31:0] crit_over;
    logic [23:0] crit_mean;
    logic [5:0]  rank;
    logic [23:0] top;
    logic        last;
  } stats_beat_t;

  // Scoreboard: tracks block statistics and the queue of expected beats
  class stats_scoreboard;
    logic [23:0] budget;
    logic [31:0] n_samples;
    logic [23:0] mean;
    logic [23:0] mad;
    logic [23:0] maxv;
    logic [31:0] over;
    logic [31:0] crit_over;
    logic [23:0] crit_mean;
    logic [23:0] tops[TOPN];
    stats_beat_t pending[$];
    int errors;
    int beats_checked;

    function void clear_all();
      n_samples = '0; mean = '0; mad = '0; maxv = '0;
      over = '0; crit_over = '0; crit_mean = '0;
      foreach (tops[i]) tops[i] = '0;
    endfunction

    function logic [31:0] sat_inc(logic [31:0] v);
      return (v == CNT_MAX) ? v : v + 32'd1;
    endfunction

    // Step old toward x by (x - old) / n, quotient truncated toward zero
    function logic [23:0] step_mean(logic [23:0] old, logic [23:0] x, logic [31:0] n);
      longint d;
      longint q;
      d = longint'(x) - longint'(old);
      q = d / longint'(n);
      return 24'(longint'(old) + q);
    endfunction

    function void note_input(logic func, logic [23:0] x, logic crit, logic [15:0] ccnt);
      logic [23:0] dv;
      logic [23:0] v;
      logic [23:0] t;
      int lim;
      stats_beat_t b;
      v = x;
      if (func == FUNC_CLEAR) begin
        clear_all();
      end else if (n_samples == 0) begin
        n_samples = 32'd1; mean = x; mad = '0; maxv = '0;
      end else begin
        n_samples = sat_inc(n_samples);
        mean = step_mean(mean, x, n_samples);
        dv = (x >= mean) ? x - mean : mean - x;
        mad = step_mean(mad, dv, n_samples);
        if (x > maxv) maxv = x;
        if (budget != 0 && x > budget) begin
          over = sat_inc(over);
          if (crit) begin
            crit_over = sat_inc(crit_over);
            crit_mean = step_mean(crit_mean, x, (ccnt == 0) ? 32'd1 : 32'(ccnt));
          end
        end
        lim = (n_samples < TOPN) ? int'(n_samples) : TOPN;
        for (int i = 0; i < lim; i++) begin
          t = tops[i];
          if (v > t) begin
            tops[i] = v;
            v = t;
          end
        end
      end
      for (int k = 0; k < TOPN; k++) begin
        b.count = n_samples; b.mean = mean; b.mad = mad; b.maxv = maxv;
        b.over = over; b.crit_over = crit_over; b.crit_mean = crit_mean;
        b.rank = 6'(k); b.top = tops[k]; b.last = (k == TOPN - 1);
        pending.insert(pending.size(), b);
      end
    endfunction

    function void check_beat(stats_beat_t a);
      stats_beat_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result beat rank %0d", $time, a.rank);
        errors++;
        return;
      end
      e = pending.pop_front();
      beats_checked++;
      if (a.count !== e.count) report("count", e.count, a.count);
      if (a.mean !== e.mean) report("mean_ms", 32'(e.mean), 32'(a.mean));
      if (a.mad !== e.mad) report("mean_abs_dev_ms", 32'(e.mad), 32'(a.mad));
      if (a.maxv !== e.maxv) report("max_ms", 32'(e.maxv), 32'(a.maxv));
      if (a.over !== e.over) report("over_budget", e.over, a.over);
      if (a.crit_over !== e.crit_over)
        report("critical_over_budget", e.crit_over, a.crit_over);
      if (a.crit_mean !== e.crit_mean)
        report("critical_mean_ms", 32'(e.crit_mean), 32'(a.crit_mean));
      if (a.rank !== e.rank) report("rank", 32'(e.rank), 32'(a.rank));
      if (a.top !== e.top) report("top_value_ms", 32'(e.top), 32'(a.top));
      if (a.last !== e.last) report("last", 32'(e.last), 32'(a.last));
    endfunction

    function void report(string fld, logic [31:0] e, logic [31:0] a);
      $display("%0t: %s mismatch expected %0h actual %0h", $time, fld, e, a);
      errors++;
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic        in_func;
  logic [23:0] in_sample_ms;
  logic        in_in_critical_frame;
  logic [15:0] in_critical_frame_count;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] out_count;
  logic [23:0] out_mean_ms;
  logic [23:0] out_mean_abs_dev_ms;
  logic [23:0] out_max_ms;
  logic [31:0] out_over_budget;
  logic [31:0] out_critical_over_budget;
  logic [23:0] out_critical_mean_ms;
  logic [5:0]  out_rank;
  logic [23:0] out_top_value_ms;
  logic        out_last;
  logic        cfg_we;
  logic [23:0] cfg_budget_ms;

  stats_scoreboard sb;
  int  idle_cycles;
  int  samples_sent;
  bit  hold_off_req;

  frame_time_statistics #(.TOP_COUNT(TOPN)) DUT (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Short gaps mostly, a long one now and then
  function int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  task automatic write_budget(logic [23:0] v);
    cfg_we <= 1'b1;
    cfg_budget_ms <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.budget = v;
  endtask

  // Offer one beat and hold it until accepted; back to back when the gap is zero
  task automatic send_item(logic func, logic [23:0] x, logic crit, logic [15:0] ccnt);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_func <= func;
    in_sample_ms <= x;
    in_in_critical_frame <= crit;
    in_critical_frame_count <= ccnt;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_input(func, x, crit, ccnt);
    samples_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  task automatic random_add(logic [23:0] budget);
    logic [23:0] x;
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) x = 24'($urandom_range(0, 24'h00FFFF));
    else if (r < 6) x = budget + 24'($urandom_range(0, 512)) - 24'd256;
    else if (r < 7) x = 24'hFFFFFF - 24'($urandom_range(0, 15));
    else x = 24'($urandom());
    send_item(FUNC_ADD, x, 1'($urandom()), 16'($urandom_range(0, 3) == 0 ?
              $urandom_range(0, 4) : $urandom()));
  endtask

  // Result side: random stalls plus one long hold-off on request
  initial begin
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        out_ready <= 1'b0;
        repeat (2000) @(posedge clk);
        hold_off_req = 1'b0;
      end else if ($urandom_range(0, 99) < 8) begin
        out_ready <= 1'b0;
        repeat (pick_gap()) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Check every accepted result beat
  always @(posedge clk) begin
    stats_beat_t b;
    if (rst_n && out_valid && out_ready) begin
      b.count = out_count; b.mean = out_mean_ms; b.mad = out_mean_abs_dev_ms;
      b.maxv = out_max_ms; b.over = out_over_budget;
      b.crit_over = out_critical_over_budget; b.crit_mean = out_critical_mean_ms;
      b.rank = out_rank; b.top = out_top_value_ms; b.last = out_last;
      sb.check_beat(b);
    end
  end

  // Watchdog on cycles with no beat moving
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= CNT_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    logic [23:0] budgets[5];
    sb = new();
    sb.budget = '0;
    sb.clear_all();
    samples_sent = 0;
    hold_off_req = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_func = FUNC_ADD;
    in_sample_ms = '0;
    in_in_critical_frame = 1'b0;
    in_critical_frame_count = '0;
    cfg_we = 1'b0;
    cfg_budget_ms = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: first sample, extremes, zero budget, clear
    write_budget(24'd0);
    send_item(FUNC_ADD, 24'hFFFFFF, 1'b1, 16'd0);
    send_item(FUNC_ADD, 24'd0, 1'b1, 16'd1);
    send_item(FUNC_ADD, 24'hFFFFFF, 1'b1, 16'hFFFF);
    send_item(FUNC_CLEAR, 24'h123456, 1'b1, 16'd7);
    send_item(FUNC_ADD, 24'd0, 1'b0, 16'd1);
    send_item(FUNC_ADD, 24'd100, 1'b0, 16'd1);
    drain();
    write_budget(24'd50);
    for (int i = 0; i < 18; i++)
      send_item(FUNC_ADD, 24'(i * 37 + 40), 1'(i), 16'(i % 4));
    send_item(FUNC_ADD, 24'hAAAAAA, 1'b1, 16'hFFFF);
    send_item(FUNC_ADD, 24'h555555, 1'b1, 16'h5555);
    drain();

    // Random phases over several budgets, extremes included
    budgets = '{24'd0, 24'hFFFFFF, 24'h000800, 24'h7FFFFF, 24'd1};
    foreach (budgets[p]) begin
      write_budget(budgets[p]);
      if (p == 2) hold_off_req = 1'b1;
      for (int i = 0; i < 52; i++) begin
        if ($urandom_range(0, 39) == 0)
          send_item(FUNC_CLEAR, 24'($urandom()), 1'($urandom()), 16'($urandom()));
        else
          random_add(budgets[p]);
      end
      drain();
    end

    $display("Ran %0d input beats and %0d result beats over five budget settings,",
             samples_sent, sb.beats_checked);
    $display("including clears, extremes, zero divisor and a long result stall.");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
